[hdl/fcc_pkg.sv]
// shared types, codes and constants for the flash command controller
`timescale 1ns / 1ps
`default_nettype none
package fcc_pkg;

   // store geometry
   localparam int STORE_WORDS = 32768;
   localparam int STORE_AW    = $clog2(STORE_WORDS);
   localparam int PAGE_WORDS  = 32;
   localparam int PAGE_AW     = $clog2(PAGE_WORDS);

   // byte address of a data read: start_offset * 2 + word_index * 4
   localparam int BYTE_AW = 18;
   localparam int WORD_AW = BYTE_AW - 2;

   localparam logic [31:0] ONES_WORD = 32'hFFFF_FFFF;

   // status words loaded by the mode commands
   localparam logic [63:0] STATUS_ID     = 64'h1111_8001_00C2_0000;
   localparam logic [63:0] STATUS_READ   = 64'h1111_8004_F000_0000;
   localparam logic [63:0] STATUS_ERASE  = 64'h1111_8008_00C2_0000;
   localparam logic [63:0] STATUS_PAGE   = 64'h1111_8004_00C2_0000;

   // bus access kinds
   typedef enum logic [1:0] {
      BUS_COMMAND     = 2'd0,
      BUS_PAGE_WRITE  = 2'd1,
      BUS_DATA_READ   = 2'd2,
      BUS_STATUS_READ = 2'd3
   } bus_mode_type;

   // command opcodes (top byte of the command word)
   typedef enum logic [7:0] {
      OP_COMMIT      = 8'hD2,
      OP_STATUS      = 8'hE1,
      OP_READ        = 8'hF0,
      OP_PAGE        = 8'h4B,
      OP_ERASE       = 8'h78,
      OP_WRITE       = 8'hB4,
      OP_PAGE_STATUS = 8'hA5
   } opcode_type;

   // device modes
   typedef enum logic [2:0] {
      DEV_IDLE   = 3'd0,
      DEV_ERASE  = 3'd1,
      DEV_WRITE  = 3'd2,
      DEV_READ   = 3'd3,
      DEV_STATUS = 3'd4
   } dev_mode_type;

   // result codes
   typedef enum logic [1:0] {
      RC_OK          = 2'd0,
      RC_WRONG_MODE  = 2'd1,
      RC_UNKNOWN_CMD = 2'd2,
      RC_OUT_OF_RANGE = 2'd3
   } result_code_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR     = 3'd0,
      ST_IDLE      = 3'd1,
      ST_READ_A    = 3'd2,
      ST_READ_B    = 3'd3,
      ST_READ_C    = 3'd4,
      ST_COMMIT_RD = 3'd5,
      ST_COMMIT_WR = 3'd6
   } state_type;

endpackage
`default_nettype wire

[hdl/flashram_command_controller.sv]
// flash command controller: command register, page buffer and word store
//
// Each bus access (command write, page data write, data read, status read) is
// one item, taken when start is high and busy is low; its single result shows
// on rsp_read_data / rsp_result_code for exactly one cycle, marked by
// rsp_valid, and cannot be held off by the receiver. Command writes other
// than a commit in erase or write mode, page data writes, data reads outside
// read mode and status register reads leave busy low: the result is registered
// and appears in the next cycle while a new item can already be taken. A data
// read in read mode needs two accesses through the single read port of the
// store and keeps busy high through ST_READ_A, ST_READ_B and ST_READ_C. A
// commit in erase or write mode moves each of the 32 page words by a page
// buffer read and then a store write, with busy high. After reset all 32768
// store words are set to all ones (one word per cycle) while busy is high.
`timescale 1ns / 1ps
`default_nettype none
module flashram_command_controller (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_mode,
   input  wire logic [31:0] req_command_word,
   input  wire logic [15:0] req_start_offset,
   input  wire logic [13:0] req_word_index,
   input  wire logic [31:0] req_write_data,
   output logic             rsp_valid,
   output logic [31:0]      rsp_read_data,
   output logic [1:0]       rsp_result_code
);
   import fcc_pkg::*;

   localparam logic [31:0] STORE_WORDS_U = 32'(STORE_WORDS);

   // sequencer and device state
   state_type            state_ff, state_in;
   dev_mode_type         dev_mode_ff, dev_mode_in;
   logic [63:0]          status_ff, status_in;
   logic [15:0]          page_num_ff, page_num_in;
   logic [STORE_AW-1:0]  clear_cnt_ff, clear_cnt_in;
   logic [PAGE_AW-1:0]   commit_idx_ff, commit_idx_in;
   logic                 commit_oob_ff, commit_oob_in;
   logic [BYTE_AW-1:0]   byte_addr_ff, byte_addr_in;
   logic [31:0]          word0_ff, word0_in;

   // result registers
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_data_ff, rsp_data_in;
   result_code_type      rsp_code_ff, rsp_code_in;

   // memory ports
   logic                 st_we;
   logic [STORE_AW-1:0]  st_waddr;
   logic [31:0]          st_wdata;
   logic [STORE_AW-1:0]  st_raddr;
   logic [31:0]          st_rdata;
   logic                 pb_we;
   logic [PAGE_AW-1:0]   pb_waddr;
   logic [PAGE_AW-1:0]   pb_raddr;
   logic [31:0]          pb_rdata;

   // decode helpers
   logic                 accept;
   opcode_type           opcode;
   logic [31:0]          rd_w0, rd_w1, cmt_word;
   logic                 rd_in0, rd_in1, cmt_in;
   logic                 commit_last;

   assign accept      = start && (state_ff == ST_IDLE);
   assign opcode      = opcode_type'(req_command_word[31:24]);
   assign rd_w0       = 32'(byte_addr_ff[BYTE_AW-1:2]);
   assign rd_w1       = rd_w0 + 32'd1;
   assign rd_in0      = rd_w0 < STORE_WORDS_U;
   assign rd_in1      = rd_w1 < STORE_WORDS_U;
   assign cmt_word    = (32'(page_num_ff) << PAGE_AW) + 32'(commit_idx_ff);
   assign cmt_in      = cmt_word < STORE_WORDS_U;
   assign commit_last = commit_idx_ff == PAGE_AW'(PAGE_WORDS - 1);

   // word store and page buffer
   fcc_ram #(.WIDTH(32), .DEPTH(STORE_WORDS)) u_store (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   fcc_ram #(.WIDTH(32), .DEPTH(PAGE_WORDS)) u_page_buf (
      .clock   (clock),
      .wr_en   (pb_we),
      .wr_addr (pb_waddr),
      .wr_data (req_write_data),
      .rd_addr (pb_raddr),
      .rd_data (pb_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clear_cnt_ff == STORE_AW'(STORE_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == BUS_COMMAND && opcode == OP_COMMIT &&
                   (dev_mode_ff == DEV_ERASE || dev_mode_ff == DEV_WRITE)) begin
                  state_in = ST_COMMIT_RD;
               end else if (req_mode == BUS_DATA_READ && dev_mode_ff == DEV_READ) begin
                  state_in = ST_READ_A;
               end
            end
         end
         ST_READ_A:    state_in = ST_READ_B;
         ST_READ_B:    state_in = ST_READ_C;
         ST_READ_C:    state_in = ST_IDLE;
         ST_COMMIT_RD: state_in = ST_COMMIT_WR;
         ST_COMMIT_WR: begin
            state_in = commit_last ? ST_IDLE : ST_COMMIT_RD;
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      dev_mode_in   = dev_mode_ff;
      status_in     = status_ff;
      page_num_in   = page_num_ff;
      clear_cnt_in  = clear_cnt_ff;
      commit_idx_in = commit_idx_ff;
      commit_oob_in = commit_oob_ff;
      byte_addr_in  = byte_addr_ff;
      word0_in      = word0_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = 32'd0;
      rsp_code_in   = RC_OK;
      st_we         = 1'b0;
      st_waddr      = clear_cnt_ff;
      st_wdata      = ONES_WORD;
      st_raddr      = rd_w0[STORE_AW-1:0];
      pb_we         = 1'b0;
      pb_waddr      = req_word_index[PAGE_AW-1:0];
      pb_raddr      = commit_idx_ff;

      case (state_ff)
         // fill the store with erased words
         ST_CLEAR: begin
            st_we        = 1'b1;
            clear_cnt_in = clear_cnt_ff + STORE_AW'(1);
         end

         // take one bus access
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               case (bus_mode_type'(req_mode))
                  BUS_COMMAND: begin
                     case (opcode)
                        OP_COMMIT: begin
                           if (dev_mode_ff == DEV_ERASE || dev_mode_ff == DEV_WRITE) begin
                              rsp_valid_in  = 1'b0;
                              commit_idx_in = '0;
                              commit_oob_in = 1'b0;
                           end else begin
                              dev_mode_in = DEV_IDLE;
                           end
                        end
                        OP_STATUS: begin
                           dev_mode_in = DEV_STATUS;
                           status_in   = STATUS_ID;
                        end
                        OP_READ: begin
                           dev_mode_in = DEV_READ;
                           status_in   = STATUS_READ;
                        end
                        OP_PAGE: begin
                           page_num_in = req_command_word[15:0];
                        end
                        OP_ERASE: begin
                           dev_mode_in = DEV_ERASE;
                           status_in   = STATUS_ERASE;
                        end
                        OP_WRITE: begin
                           dev_mode_in = DEV_WRITE;
                        end
                        OP_PAGE_STATUS: begin
                           page_num_in = req_command_word[15:0];
                           status_in   = STATUS_PAGE;
                        end
                        default: begin
                           rsp_code_in = RC_UNKNOWN_CMD;
                        end
                     endcase
                  end
                  BUS_PAGE_WRITE: begin
                     if (dev_mode_ff != DEV_WRITE) begin
                        rsp_code_in = RC_WRONG_MODE;
                     end else if (32'(req_word_index) >= 32'(PAGE_WORDS)) begin
                        rsp_code_in = RC_OUT_OF_RANGE;
                     end else begin
                        pb_we = 1'b1;
                     end
                  end
                  BUS_DATA_READ: begin
                     if (dev_mode_ff == DEV_READ) begin
                        rsp_valid_in = 1'b0;
                        byte_addr_in = BYTE_AW'({req_start_offset, 1'b0}) +
                                       BYTE_AW'({req_word_index, 2'b00});
                     end else if (dev_mode_ff == DEV_STATUS) begin
                        if (req_word_index == 14'd0) begin
                           rsp_data_in = status_ff[63:32];
                        end else if (req_word_index == 14'd1) begin
                           rsp_data_in = status_ff[31:0];
                        end else begin
                           rsp_code_in = RC_OUT_OF_RANGE;
                        end
                     end else begin
                        rsp_code_in = RC_WRONG_MODE;
                     end
                  end
                  BUS_STATUS_READ: begin
                     rsp_data_in = status_ff[63:32];
                  end
                  default: begin
                     rsp_code_in = RC_OK;
                  end
               endcase
            end
         end

         // store read: first word issued
         ST_READ_A: begin
            st_raddr = rd_w0[STORE_AW-1:0];
         end

         // first word back, second word issued
         ST_READ_B: begin
            word0_in = rd_in0 ? st_rdata : ONES_WORD;
            st_raddr = rd_w1[STORE_AW-1:0];
         end

         // second word back, assemble little-endian bytes
         ST_READ_C: begin
            rsp_valid_in = 1'b1;
            if (byte_addr_ff[1]) begin
               rsp_data_in = {(rd_in1 ? st_rdata[15:0] : ONES_WORD[15:0]), word0_ff[31:16]};
            end else begin
               rsp_data_in = word0_ff;
            end
            if (!rd_in0 || (byte_addr_ff[1] && !rd_in1)) begin
               rsp_code_in = RC_OUT_OF_RANGE;
            end
         end

         // commit: page buffer word requested
         ST_COMMIT_RD: begin
            pb_raddr = commit_idx_ff;
         end

         // commit: store word written, words past the store dropped
         ST_COMMIT_WR: begin
            st_waddr = cmt_word[STORE_AW-1:0];
            st_wdata = (dev_mode_ff == DEV_ERASE) ? ONES_WORD : pb_rdata;
            if (cmt_in) begin
               st_we = 1'b1;
            end else begin
               commit_oob_in = 1'b1;
            end
            commit_idx_in = commit_idx_ff + PAGE_AW'(1);
            if (commit_last) begin
               dev_mode_in  = DEV_IDLE;
               rsp_valid_in = 1'b1;
               rsp_code_in  = (commit_oob_ff || !cmt_in) ? RC_OUT_OF_RANGE : RC_OK;
            end
         end

         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         dev_mode_ff  <= DEV_IDLE;
         status_ff    <= 64'd0;
         page_num_ff  <= 16'd0;
         clear_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dev_mode_ff  <= dev_mode_in;
         status_ff    <= status_in;
         page_num_ff  <= page_num_in;
         clear_cnt_ff <= clear_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      commit_idx_ff <= commit_idx_in;
      commit_oob_ff <= commit_oob_in;
      byte_addr_ff  <= byte_addr_in;
      word0_ff      <= word0_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_code_ff   <= rsp_code_in;
   end

   // outputs
   assign busy            = state_ff != ST_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_data_ff;
   assign rsp_result_code = rsp_code_ff;

endmodule
`default_nettype wire

[hdl/fcc_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module fcc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[hdl/fcc_checker.sv]
// port-level checks for the flash command controller, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module fcc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic [1:0]  req_mode,
   input wire logic        rsp_valid,
   input wire logic [1:0]  rsp_result_code
);
   import fcc_pkg::*;

   // reset starts the clearing pass with no result pending
   a_reset_busy: assert property (@(posedge clock) reset |=> busy && !rsp_valid)
      else $error("controller not busy or result shown after reset");

   // a result only shows once the sequencer is free again
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // every result follows a transfer or the end of a busy stretch
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(start) && !$past(busy)) || $past(busy))
      else $error("result with no transfer behind it");

   // a status register read answers in the next cycle with an ok code
   a_status_read: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_mode == BUS_STATUS_READ) |=>
         (rsp_valid && rsp_result_code == RC_OK))
      else $error("status register read not answered");

endmodule

bind flashram_command_controller fcc_checker u_fcc_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_mode        (req_mode),
   .rsp_valid       (rsp_valid),
   .rsp_result_code (rsp_result_code)
);
`default_nettype wire
